// ===== src/dns_name_suffix_matcher_top_macros.svh =====
// ---------------------------------------------------------------------------
// dns name suffix matcher assertion macros
// shared concurrent assertion forms, clocked on rising edge, reset active low
// ---------------------------------------------------------------------------
`ifndef DNS_NAME_SUFFIX_MATCHER_TOP_MACROS_SVH
`define DNS_NAME_SUFFIX_MATCHER_TOP_MACROS_SVH

// same-cycle implication
`define DNSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsm assertion failed");

// next-cycle implication
`define DNSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsm assertion failed");

`endif

// ===== src/dnsm_pkg.sv =====
// ---------------------------------------------------------------------------
// dnsm_pkg
// shared types and constants for the dns name suffix matcher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnsm_pkg;

    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWALK_RD,
        ST_SWALK_EV,
        ST_LWALK_RD,
        ST_LWALK_EV,
        ST_BWALK_RD,
        ST_BWALK_EV,
        ST_CMP_RD,
        ST_CMP_EV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;      // input request taken this cycle
        logic sel_long;    // walk reads the long name store
        logic addr_cmp;    // stores addressed by the compare index
        logic clr_result;
        logic walk_start;
        logic walk_step;
        logic set_len;
        logic cmp_start;
        logic cmp_step;
        logic set_found;
        logic load_out;
        logic clr_names;
    } t_ctrl_cmd;

    typedef struct packed {
        logic walk_end;    // position past loaded bytes or store overflowed
        logic byte_zero;
        logic hit;         // walk position equals candidate boundary
        logic past;        // walk position beyond candidate boundary
        logic no_room;     // suffix longer than the long name
        logic mismatch;
        logic cmp_last;
        logic sok;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/dnsm_datapath.sv =====
// ---------------------------------------------------------------------------
// dnsm_datapath
// name stores, label walker, folded byte compare and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnsm_datapath #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dnsm_pkg::t_ctrl_cmd              i_cmd,
    output dnsm_pkg::t_dp_status             o_status,
    input  logic [dnsm_pkg::BYTE_W-1:0]      i_s_data,
    input  logic                             i_s_kind,
    input  logic                             i_s_last,
    input  logic                             i_m_ready,
    output logic                             o_m_valid,
    output logic [dnsm_pkg::OUT_DATA_W-1:0]  o_m_data
);

    localparam int AW = $clog2(MAX_NAME_BYTES);
    localparam int CW = $clog2(MAX_NAME_BYTES + 1);
    localparam int PW = $clog2(MAX_NAME_BYTES + 257);
    localparam int XW = (CW > 8) ? CW : 8;

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
    endfunction

    function automatic logic [7:0] sat8(input logic [XW-1:0] v);
        return (v > XW'(255)) ? 8'hFF : v[7:0];
    endfunction

    logic [7:0]    r_short_mem [MAX_NAME_BYTES];
    logic [7:0]    r_long_mem  [MAX_NAME_BYTES];
    logic [7:0]    r_short_rd;
    logic [7:0]    r_long_rd;

    logic [CW-1:0] r_scount;
    logic [CW-1:0] r_lcount;
    logic          r_short_over;
    logic          r_long_over;
    logic          r_short_closed;

    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_target;
    logic [CW-1:0] r_slen;
    logic [CW-1:0] r_llen;
    logic          r_sok;
    logic          r_lok;
    logic          r_found;

    logic                            r_out_valid;
    logic [dnsm_pkg::OUT_DATA_W-1:0] r_out_data;

    logic          w_short_we;
    logic [AW-1:0] w_short_waddr;
    logic          w_long_we;
    logic [AW-1:0] w_short_raddr;
    logic [AW-1:0] w_long_raddr;
    logic [CW-1:0] w_cmp_laddr;
    logic [7:0]    w_walk_byte;
    logic [CW-1:0] w_target;
    logic [CW-1:0] w_count_sel;
    logic          w_over_sel;
    logic          w_short_in;
    logic          w_long_in;

    assign w_short_in = i_cmd.accept && (i_s_kind == dnsm_pkg::KIND_SHORT);
    assign w_long_in  = i_cmd.accept && (i_s_kind == dnsm_pkg::KIND_LONG);

    // a closed suffix restarts at entry zero
    assign w_short_we    = w_short_in && (r_short_closed || (r_scount < CW'(MAX_NAME_BYTES)));
    assign w_short_waddr = r_short_closed ? '0 : r_scount[AW-1:0];
    assign w_long_we     = w_long_in && (r_lcount < CW'(MAX_NAME_BYTES));

    assign w_cmp_laddr   = r_target + r_idx;
    assign w_short_raddr = i_cmd.addr_cmp ? r_idx[AW-1:0] : r_pos[AW-1:0];
    assign w_long_raddr  = i_cmd.addr_cmp ? w_cmp_laddr[AW-1:0] : r_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_short_we) begin
            r_short_mem[w_short_waddr] <= i_s_data;
        end
        r_short_rd <= r_short_mem[w_short_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_long_we) begin
            r_long_mem[r_lcount[AW-1:0]] <= i_s_data;
        end
        r_long_rd <= r_long_mem[w_long_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scount       <= '0;
            r_lcount       <= '0;
            r_short_over   <= 1'b0;
            r_long_over    <= 1'b0;
            r_short_closed <= 1'b0;
        end else if (i_cmd.clr_names) begin
            r_scount       <= '0;
            r_lcount       <= '0;
            r_short_over   <= 1'b0;
            r_long_over    <= 1'b0;
            r_short_closed <= 1'b0;
        end else begin
            if (w_short_in) begin
                r_short_closed <= i_s_last;
                if (r_short_closed) begin
                    r_scount     <= CW'(1);
                    r_short_over <= 1'b0;
                end else if (r_scount < CW'(MAX_NAME_BYTES)) begin
                    r_scount <= r_scount + CW'(1);
                end else begin
                    r_short_over <= 1'b1;
                end
            end
            if (w_long_in) begin
                if (w_long_we) begin
                    r_lcount <= r_lcount + CW'(1);
                end else begin
                    r_long_over <= 1'b1;
                end
            end
        end
    end

    assign w_walk_byte = i_cmd.sel_long ? r_long_rd : r_short_rd;
    assign w_count_sel = i_cmd.sel_long ? r_lcount : r_scount;
    assign w_over_sel  = i_cmd.sel_long ? r_long_over : r_short_over;
    assign w_target    = r_llen - r_slen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sok   <= 1'b0;
            r_lok   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.clr_result) begin
                r_sok   <= 1'b0;
                r_lok   <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.set_len) begin
                if (i_cmd.sel_long) begin
                    r_lok <= 1'b1;
                end else begin
                    r_sok <= 1'b1;
                end
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_result || i_cmd.walk_start) begin
            r_pos <= '0;
        end else if (i_cmd.walk_step) begin
            r_pos <= r_pos + PW'(w_walk_byte) + PW'(1);
        end
        if (i_cmd.clr_result) begin
            r_slen <= '0;
            r_llen <= '0;
        end else if (i_cmd.set_len) begin
            if (i_cmd.sel_long) begin
                r_llen <= r_pos[CW-1:0] + CW'(1);
            end else begin
                r_slen <= r_pos[CW-1:0] + CW'(1);
            end
        end
        if (i_cmd.cmp_start) begin
            r_idx    <= '0;
            r_target <= w_target;
        end else if (i_cmd.cmp_step) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    always_comb begin
        o_status.walk_end  = w_over_sel || (r_pos >= PW'(w_count_sel));
        o_status.byte_zero = (w_walk_byte == 8'h00);
        o_status.hit       = (r_pos == PW'(w_target));
        o_status.past      = (r_pos > PW'(w_target));
        o_status.no_room   = (r_slen > r_llen);
        o_status.mismatch  = (fold(r_short_rd) != fold(r_long_rd));
        o_status.cmp_last  = ((r_idx + CW'(1)) == r_slen);
        o_status.sok       = r_sok;
        o_status.out_free  = !r_out_valid || i_m_ready;
    end

    // result fields from bit 0: is_suffix, suffix_offset, names_equal,
    // long_length, short_length, malformed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {5'b0,
                           !(r_sok && r_lok),
                           r_sok ? sat8(XW'(r_slen)) : 8'h00,
                           r_lok ? sat8(XW'(r_llen)) : 8'h00,
                           r_found && (r_target == '0),
                           r_found ? sat8(XW'(r_target)) : 8'h00,
                           r_found};
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

endmodule

// ===== src/dnsm_ctrl.sv =====
// ---------------------------------------------------------------------------
// dnsm_ctrl
// sequencer for loading, label walks, suffix compare and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnsm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_kind,
    input  logic                  i_s_last,
    output logic                  o_s_ready,
    input  dnsm_pkg::t_dp_status  i_status,
    output dnsm_pkg::t_ctrl_cmd   o_cmd
);

    dnsm_pkg::t_state r_state;
    dnsm_pkg::t_state n_state;
    logic             w_accept;

    assign o_s_ready = (r_state == dnsm_pkg::ST_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dnsm_pkg::ST_IDLE: begin
                if (w_accept && (i_s_kind == dnsm_pkg::KIND_LONG) && i_s_last) begin
                    n_state = dnsm_pkg::ST_SWALK_RD;
                end
            end
            dnsm_pkg::ST_SWALK_RD: begin
                n_state = i_status.walk_end ? dnsm_pkg::ST_LWALK_RD : dnsm_pkg::ST_SWALK_EV;
            end
            dnsm_pkg::ST_SWALK_EV: begin
                n_state = i_status.byte_zero ? dnsm_pkg::ST_LWALK_RD : dnsm_pkg::ST_SWALK_RD;
            end
            dnsm_pkg::ST_LWALK_RD: begin
                n_state = i_status.walk_end ? dnsm_pkg::ST_DONE : dnsm_pkg::ST_LWALK_EV;
            end
            dnsm_pkg::ST_LWALK_EV: begin
                if (!i_status.byte_zero) begin
                    n_state = dnsm_pkg::ST_LWALK_RD;
                end else if (i_status.sok) begin
                    n_state = dnsm_pkg::ST_BWALK_RD;
                end else begin
                    n_state = dnsm_pkg::ST_DONE;
                end
            end
            dnsm_pkg::ST_BWALK_RD: begin
                if (i_status.no_room || i_status.past) begin
                    n_state = dnsm_pkg::ST_DONE;
                end else if (i_status.hit) begin
                    n_state = dnsm_pkg::ST_CMP_RD;
                end else begin
                    n_state = dnsm_pkg::ST_BWALK_EV;
                end
            end
            dnsm_pkg::ST_BWALK_EV: begin
                n_state = dnsm_pkg::ST_BWALK_RD;
            end
            dnsm_pkg::ST_CMP_RD: begin
                n_state = dnsm_pkg::ST_CMP_EV;
            end
            dnsm_pkg::ST_CMP_EV: begin
                if (i_status.mismatch || i_status.cmp_last) begin
                    n_state = dnsm_pkg::ST_DONE;
                end else begin
                    n_state = dnsm_pkg::ST_CMP_RD;
                end
            end
            dnsm_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = dnsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dnsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        case (r_state)
            dnsm_pkg::ST_IDLE: begin
                o_cmd.clr_result = w_accept && (i_s_kind == dnsm_pkg::KIND_LONG) && i_s_last;
            end
            dnsm_pkg::ST_SWALK_RD: begin
                o_cmd.walk_start = i_status.walk_end;
            end
            dnsm_pkg::ST_SWALK_EV: begin
                o_cmd.set_len    = i_status.byte_zero;
                o_cmd.walk_start = i_status.byte_zero;
                o_cmd.walk_step  = !i_status.byte_zero;
            end
            dnsm_pkg::ST_LWALK_RD: begin
                o_cmd.sel_long = 1'b1;
            end
            dnsm_pkg::ST_LWALK_EV: begin
                o_cmd.sel_long   = 1'b1;
                o_cmd.set_len    = i_status.byte_zero;
                o_cmd.walk_start = i_status.byte_zero;
                o_cmd.walk_step  = !i_status.byte_zero;
            end
            dnsm_pkg::ST_BWALK_RD: begin
                o_cmd.sel_long  = 1'b1;
                o_cmd.cmp_start = !i_status.no_room && !i_status.past && i_status.hit;
            end
            dnsm_pkg::ST_BWALK_EV: begin
                o_cmd.sel_long  = 1'b1;
                o_cmd.walk_step = 1'b1;
            end
            dnsm_pkg::ST_CMP_RD: begin
                o_cmd.addr_cmp = 1'b1;
            end
            dnsm_pkg::ST_CMP_EV: begin
                o_cmd.addr_cmp  = 1'b1;
                o_cmd.set_found = !i_status.mismatch && i_status.cmp_last;
                o_cmd.cmp_step  = !i_status.mismatch && !i_status.cmp_last;
            end
            dnsm_pkg::ST_DONE: begin
                o_cmd.load_out  = i_status.out_free;
                o_cmd.clr_names = i_status.out_free;
            end
            default: begin
                o_cmd.accept = w_accept;
            end
        endcase
    end

endmodule

// ===== src/dns_name_suffix_matcher_top.sv =====
// ---------------------------------------------------------------------------
// dns_name_suffix_matcher_top
// checks whether one dns wire-format name is a label-aligned suffix of another
// ---------------------------------------------------------------------------
// Name bytes load one per cycle: first the suffix name (tuser 0), then the
// longer name (tuser 1), each closed by tlast. The last byte of the longer
// name starts the check and input stalls until the result is registered.
// The check walks the suffix labels, then the longer name's labels, then the
// longer name again up to the one candidate boundary, and then compares the
// suffix byte by byte; every step waits on a registered read of a name store.
// A mismatch, a suffix longer than the longer name or a malformed name ends
// the check before the compare runs to the end, and a result still held in
// the output register adds its wait to the input stall.
// No clearing pass follows reset. A finished result waits in the output
// register while the next names load.
`timescale 1ns / 1ps

module dns_name_suffix_matcher_top #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] name_byte
    input  logic        i_s_axis_tuser,   // [0] kind
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [0] is_suffix, [8:1] suffix_offset,
                                          // [9] names_equal, [17:10] long_length,
                                          // [25:18] short_length, [26] malformed
);

    dnsm_pkg::t_ctrl_cmd  w_cmd;
    dnsm_pkg::t_dp_status w_status;

    dnsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_kind  (i_s_axis_tuser),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    dnsm_datapath #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_s_data  (i_s_axis_tdata),
        .i_s_kind  (i_s_axis_tuser),
        .i_s_last  (i_s_axis_tlast),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata)
    );

`include "dns_name_suffix_matcher_top_macros.svh"

    // closing byte of the longer name stalls input while the check runs
    `DNSM_ASSERT_NEXT(a_stall_after_long_last, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && i_s_axis_tlast,
        !o_s_axis_tready)

    // a result is never loaded over one still waiting
    `DNSM_ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n,
        w_cmd.load_out, !o_m_axis_tvalid || i_m_axis_tready)

    // a malformed request reports no match
    `DNSM_ASSERT_IMPLY(a_malformed_no_match, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[26],
        !o_m_axis_tdata[0] && !o_m_axis_tdata[9])

    // equal names are a match at offset zero
    `DNSM_ASSERT_IMPLY(a_equal_is_suffix, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[9],
        o_m_axis_tdata[0] && (o_m_axis_tdata[8:1] == 8'h00))

endmodule
